// ===== rtl/rsst_pkg.sv =====
// ----------------------------------------------------------------------------
// rsst_pkg
// Shared constants, state encoding and the memory request type for the
// range-sum segment tree.
// ----------------------------------------------------------------------------
package rsst_pkg;

  localparam int NUM_ELEMENTS = 1024;
  localparam int LEVELS       = $clog2(NUM_ELEMENTS);
  // Node memory is heap ordered from address 1; leaves start at NUM_ELEMENTS
  localparam int ADDR_W       = LEVELS + 1;
  // Query cursors reach 2*NUM_ELEMENTS, one past the last node
  localparam int POS_W        = LEVELS + 2;
  localparam int IDX_W        = 10;
  localparam int DATA_W       = 32;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_UPD   = 5'b00100,
    ST_QRY   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== rtl/rsst_ram.sv =====
// ----------------------------------------------------------------------------
// rsst_ram
// Node-sum memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rsst_ram (
  input  logic                          clk,
  input  rsst_pkg::mem_req_t            req,
  output logic [rsst_pkg::DATA_W-1:0]   rdata
);

  logic [rsst_pkg::DATA_W-1:0] mem [2**rsst_pkg::ADDR_W];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ===== rtl/rsst_ctrl.sv =====
// ----------------------------------------------------------------------------
// rsst_ctrl
// Sequencer for the segment tree: clearing pass, leaf-to-root update walk and
// bottom-up range query, all through the single node memory.
// ----------------------------------------------------------------------------
module rsst_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              command,
  input  logic [rsst_pkg::IDX_W-1:0]        index,
  input  logic [rsst_pkg::IDX_W-1:0]        right_index,
  input  logic [rsst_pkg::DATA_W-1:0]       value,
  output rsst_pkg::mem_req_t                mem_req,
  input  logic [rsst_pkg::DATA_W-1:0]       rdata,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic [rsst_pkg::DATA_W-1:0]       res_sum
);

  localparam logic [31:0] NUM_EXT  = 32'(rsst_pkg::NUM_ELEMENTS);
  localparam logic [31:0] LAST_EXT = 32'(rsst_pkg::NUM_ELEMENTS - 1);

  rsst_pkg::state_t                  state, state_next;
  logic [rsst_pkg::ADDR_W-1:0]       clr_addr, clr_addr_next;
  logic [rsst_pkg::ADDR_W-1:0]       node, node_next;
  logic [rsst_pkg::POS_W-1:0]        lpos, lpos_next;
  logic [rsst_pkg::POS_W-1:0]        rpos, rpos_next;
  logic [rsst_pkg::DATA_W-1:0]       acc, acc_next;
  logic                              rd_pend, rd_pend_next;

  logic [31:0]                       left_ext, right_ext, right_sat;
  logic [rsst_pkg::ADDR_W-1:0]       parent;
  logic [rsst_pkg::DATA_W-1:0]       acc_in;

  assign left_ext  = 32'(index);
  assign right_ext = 32'(right_index);
  assign right_sat = (right_ext > LAST_EXT) ? LAST_EXT : right_ext;
  assign parent    = node >> 1;
  assign acc_in    = acc + (rd_pend ? rdata : '0);

  assign in_ready  = (state == rsst_pkg::ST_IDLE);
  assign res_valid = (state == rsst_pkg::ST_DONE);
  assign res_sum   = acc;

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    node_next     = node;
    lpos_next     = lpos;
    rpos_next     = rpos;
    acc_next      = acc;
    rd_pend_next  = 1'b0;
    mem_req       = '0;

    unique case (state)
      rsst_pkg::ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == '1) begin
          state_next = rsst_pkg::ST_IDLE;
        end
      end

      rsst_pkg::ST_IDLE: begin
        if (in_valid) begin
          acc_next = '0;
          if (command == rsst_pkg::CMD_UPDATE) begin
            if (left_ext <= LAST_EXT) begin
              // write the leaf, fetch its sibling for the first parent
              node_next     = rsst_pkg::ADDR_W'(NUM_EXT + left_ext);
              mem_req.we    = 1'b1;
              mem_req.waddr = rsst_pkg::ADDR_W'(NUM_EXT + left_ext);
              mem_req.wdata = value;
              mem_req.re    = 1'b1;
              mem_req.raddr = rsst_pkg::ADDR_W'(NUM_EXT + left_ext)
                              ^ rsst_pkg::ADDR_W'(1);
              acc_next      = value;
              state_next    = rsst_pkg::ST_UPD;
            end else begin
              state_next = rsst_pkg::ST_DONE;
            end
          end else begin
            if (left_ext <= right_ext && left_ext <= LAST_EXT) begin
              // half-open cursor pair [lpos, rpos) over the leaf row
              lpos_next  = rsst_pkg::POS_W'(NUM_EXT + left_ext);
              rpos_next  = rsst_pkg::POS_W'(NUM_EXT + right_sat + 32'd1);
              state_next = rsst_pkg::ST_QRY;
            end else begin
              state_next = rsst_pkg::ST_DONE;
            end
          end
        end
      end

      rsst_pkg::ST_UPD: begin
        // parent sum written while the next sibling is fetched
        mem_req.we    = 1'b1;
        mem_req.waddr = parent;
        mem_req.wdata = acc + rdata;
        acc_next      = acc + rdata;
        node_next     = parent;
        if (parent == rsst_pkg::ADDR_W'(1)) begin
          acc_next   = '0;
          state_next = rsst_pkg::ST_DONE;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = parent ^ rsst_pkg::ADDR_W'(1);
        end
      end

      rsst_pkg::ST_QRY: begin
        acc_next = acc_in;
        if (lpos < rpos) begin
          if (lpos[0]) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = rsst_pkg::ADDR_W'(lpos);
            lpos_next     = lpos + 1'b1;
            rd_pend_next  = 1'b1;
          end else if (rpos[0]) begin
            // right node taken and both cursors climb in the same cycle
            mem_req.re    = 1'b1;
            mem_req.raddr = rsst_pkg::ADDR_W'(rpos - 1'b1);
            lpos_next     = lpos >> 1;
            rpos_next     = rpos >> 1;
            rd_pend_next  = 1'b1;
          end else begin
            lpos_next = lpos >> 1;
            rpos_next = rpos >> 1;
          end
        end else begin
          state_next = rsst_pkg::ST_DONE;
        end
      end

      rsst_pkg::ST_DONE: begin
        if (res_ready) begin
          state_next = rsst_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = rsst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rsst_pkg::ST_CLEAR;
      clr_addr <= '0;
      rd_pend  <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      rd_pend  <= rd_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    node <= node_next;
    lpos <= lpos_next;
    rpos <= rpos_next;
    acc  <= acc_next;
  end

endmodule

// ===== rtl/range_sum_segment_tree_top.sv =====
// ----------------------------------------------------------------------------
// range_sum_segment_tree_top
// Segment tree of 32-bit wrapping sums: point updates and inclusive range
// sum queries, one request at a time.
// ----------------------------------------------------------------------------
// After reset the node memory is swept to zero, one entry a cycle, over all
// 2*NUM_ELEMENTS (2048) entries with in_ready low. An update writes the
// leaf, then climbs one tree level per step, writing the parent sum while
// the next sibling is read, and ends in the result state. A query makes one
// node read or one level climb per cycle through the single read port of
// the node memory; an empty range goes straight to the result. A new
// request is taken while the previous result still sits in the output
// register.
// ----------------------------------------------------------------------------
module range_sum_segment_tree_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                command,
  input  logic [rsst_pkg::IDX_W-1:0]          index,
  input  logic [rsst_pkg::IDX_W-1:0]          right_index,
  input  logic signed [rsst_pkg::DATA_W-1:0]  value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rsst_pkg::DATA_W-1:0]  sum
);

  rsst_pkg::mem_req_t            mem_req;
  logic [rsst_pkg::DATA_W-1:0]   rdata;
  logic                          res_valid;
  logic                          res_ready;
  logic [rsst_pkg::DATA_W-1:0]   res_sum;

  rsst_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .index       (index),
    .right_index (right_index),
    .value       ($unsigned(value)),
    .mem_req     (mem_req),
    .rdata       (rdata),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_sum     (res_sum)
  );

  rsst_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  // output register decouples the sequencer from the consumer
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      sum <= $signed(res_sum);
    end
  end

endmodule

// ===== rtl/rsst_checker.sv =====
// ----------------------------------------------------------------------------
// rsst_checker
// Port-level checks for the segment tree, bound to the top level.
// ----------------------------------------------------------------------------
module rsst_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [rsst_pkg::DATA_W-1:0]  sum
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sum))
    else $error("result changed or dropped while stalled");

  // clearing sweep follows reset
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("request taken during clearing sweep");

  // one request in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken back to back");

  // no result appears without a request having been taken
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without a request");

endmodule

bind range_sum_segment_tree_top rsst_checker u_rsst_checker (.*);

// ===== bench/range_sum_checker.sv =====
// ----------------------------------------------------------------------------
// range_sum_checker
// Watches both channels of the segment tree, keeps a flat copy of the element
// array, predicts the sum for every accepted request and compares results in
// order.
// ----------------------------------------------------------------------------
module range_sum_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic                               command,
  input  logic [rsst_pkg::IDX_W-1:0]         index,
  input  logic [rsst_pkg::IDX_W-1:0]         right_index,
  input  logic signed [rsst_pkg::DATA_W-1:0] value,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [rsst_pkg::DATA_W-1:0] sum,
  output int                                 fail_count,
  output int                                 outstanding,
  output int                                 sums_checked,
  output int                                 queries_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [rsst_pkg::DATA_W-1:0] word_t;

  // Sums are associative mod 2^32, so a flat array gives the same answer
  // as the tree
  word_t element_vals [rsst_pkg::NUM_ELEMENTS];
  word_t expected_sums [$];

  initial begin
    fail_count   = 0;
    outstanding  = 0;
    sums_checked = 0;
    queries_seen = 0;
  end

  function automatic word_t span_total(int unsigned lo, int unsigned hi);
    word_t acc;
    acc = '0;
    // elements past the end add nothing; an empty range skips the loop
    if (hi > rsst_pkg::NUM_ELEMENTS - 1) hi = rsst_pkg::NUM_ELEMENTS - 1;
    for (int unsigned k = lo; k <= hi; k++) acc += element_vals[k];
    return acc;
  endfunction

  task automatic report_mismatch(string what, word_t got, word_t want);
    $display("[%0t] MISMATCH %s: sum got %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    word_t want;
    if (rst) begin
      foreach (element_vals[k]) element_vals[k] = '0;
      expected_sums.delete();
    end else begin
      // a result leaving now belongs to an earlier request, so retire first
      if (out_valid && out_ready) begin
        if (expected_sums.size() == 0) begin
          report_mismatch("result with no request pending", sum, 'x);
        end else begin
          want = expected_sums.pop_front();
          sums_checked++;
          if (sum !== want) report_mismatch("range sum", sum, want);
        end
      end
      if (in_valid && in_ready) begin
        want = '0;
        if (command == rsst_pkg::CMD_QUERY) begin
          queries_seen++;
          want = span_total(index, right_index);
        end else if (index <= rsst_pkg::NUM_ELEMENTS - 1) begin
          element_vals[index] = value;
        end
        expected_sums.push_back(want);
      end
    end
    outstanding <= expected_sums.size();
  end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives point updates and range sum queries into the segment tree with
// bursty requests and a stalling receiver; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 10000;  // must outlast the quiet reset clearing sweep
  localparam int LONG_HOLD  = 400;

  logic                               clk         = 1'b0;
  logic                               rst         = 1'b1;
  logic                               in_valid    = 1'b0;
  logic                               in_ready;
  logic                               command     = rsst_pkg::CMD_UPDATE;
  logic [rsst_pkg::IDX_W-1:0]         index       = '0;
  logic [rsst_pkg::IDX_W-1:0]         right_index = '0;
  logic signed [rsst_pkg::DATA_W-1:0] value       = '0;
  logic                               out_valid;
  logic                               out_ready   = 1'b0;
  logic signed [rsst_pkg::DATA_W-1:0] sum;

  int fail_count;
  int outstanding;
  int sums_checked;
  int queries_seen;

  int reqs_sent     = 0;
  int burst_left    = 1;
  bit long_hold_go  = 1'b0;

  always #5 clk = ~clk;

  range_sum_segment_tree_top i_dut (.*);

  range_sum_checker i_checker (.*);

  // Hold each request until taken, then maybe drop valid for a random gap
  task automatic send_req(logic cmd, logic [rsst_pkg::IDX_W-1:0] lo,
                          logic [rsst_pkg::IDX_W-1:0] hi,
                          logic [rsst_pkg::DATA_W-1:0] val);
    int gap;
    in_valid    <= 1'b1;
    command     <= cmd;
    index       <= lo;
    right_index <= hi;
    value       <= val;
    do @(posedge clk); while (!in_ready);
    reqs_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 10);
    end
  endtask

  // Always waits on a clock edge before returning, so valid is never lowered and raised
  // in the same step
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [rsst_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '1;
      3:       return '0;
      default: return $urandom();
    endcase
  endfunction

  task automatic gen_traffic(int count, int update_pct);
    logic [rsst_pkg::IDX_W-1:0] lo;
    logic [rsst_pkg::IDX_W-1:0] hi;
    logic [rsst_pkg::IDX_W-1:0] t;
    repeat (count) begin
      if ($urandom_range(1, 100) <= update_pct) begin
        send_req(rsst_pkg::CMD_UPDATE, rsst_pkg::IDX_W'($urandom()),
                 rsst_pkg::IDX_W'($urandom()), pick_value());
      end else begin
        lo = rsst_pkg::IDX_W'($urandom());
        hi = rsst_pkg::IDX_W'($urandom());
        case ($urandom_range(0, 9))
          0: begin  // empty range
            lo = rsst_pkg::IDX_W'($urandom_range(1, rsst_pkg::NUM_ELEMENTS - 1));
            hi = rsst_pkg::IDX_W'($urandom_range(0, lo - 1));
          end
          1: begin
            lo = '0;
            hi = '1;
          end
          2: hi = '1;
          3: lo = '0;
          4: hi = lo;
          5, 6: hi = (lo > rsst_pkg::NUM_ELEMENTS - 17) ? '1
                     : rsst_pkg::IDX_W'(32'(lo) + $urandom_range(0, 16));
          default: begin
            if (lo > hi) begin
              t  = lo;
              lo = hi;
              hi = t;
            end
          end
        endcase
        send_req(rsst_pkg::CMD_QUERY, lo, hi, $urandom());
      end
    end
  endtask

  // Receiver: changes its stall pattern every so often; a long hold on request
  initial begin : receiver
    int mode;
    int span;
    int tick;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 150);
      repeat (span) begin
        @(posedge clk);
        tick++;
        if (long_hold_go) begin
          long_hold_go = 1'b0;
          out_ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (tick % 3 == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("[%0t] watchdog: no handshake for %0d cycles", $time, IDLE_LIMIT);
    $display("testbench: errors");
    $finish;
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, wrap-around, tree mid-point, empty ranges
    send_req(rsst_pkg::CMD_QUERY,  10'd0,    10'd1023, 32'h0);
    send_req(rsst_pkg::CMD_UPDATE, 10'd0,    10'd0,    32'h7FFF_FFFF);
    send_req(rsst_pkg::CMD_UPDATE, 10'd1023, 10'd0,    32'h8000_0000);
    send_req(rsst_pkg::CMD_UPDATE, 10'd511,  10'd0,    32'hFFFF_FFFF);
    send_req(rsst_pkg::CMD_UPDATE, 10'd512,  10'd0,    32'h1);
    send_req(rsst_pkg::CMD_QUERY,  10'd0,    10'd1023, 32'h0);
    send_req(rsst_pkg::CMD_QUERY,  10'd0,    10'd0,    32'h0);
    send_req(rsst_pkg::CMD_QUERY,  10'd1023, 10'd1023, 32'h0);
    send_req(rsst_pkg::CMD_QUERY,  10'd511,  10'd512,  32'h0);
    send_req(rsst_pkg::CMD_QUERY,  10'd0,    10'd511,  32'h0);
    send_req(rsst_pkg::CMD_QUERY,  10'd512,  10'd1023, 32'h0);
    send_req(rsst_pkg::CMD_QUERY,  10'd5,    10'd4,    32'hFFFF_FFFF);
    send_req(rsst_pkg::CMD_QUERY,  10'd1023, 10'd0,    32'h0);
    send_req(rsst_pkg::CMD_UPDATE, 10'd1,    10'd0,    32'h7FFF_FFFF);
    send_req(rsst_pkg::CMD_QUERY,  10'd0,    10'd1,    32'h0);
    send_req(rsst_pkg::CMD_UPDATE, 10'd0,    10'd1023, 32'h0);
    send_req(rsst_pkg::CMD_QUERY,  10'd0,    10'd1,    32'h0);
    send_req(rsst_pkg::CMD_UPDATE, 10'd1000, 10'd0,    32'h8000_0000);
    send_req(rsst_pkg::CMD_UPDATE, 10'd1001, 10'd0,    32'h8000_0000);
    send_req(rsst_pkg::CMD_QUERY,  10'd1000, 10'd1001, 32'h0);
    send_req(rsst_pkg::CMD_UPDATE, 10'd341,  10'd0,    32'h1234_5678);
    send_req(rsst_pkg::CMD_UPDATE, 10'd682,  10'd0,    32'hEDCB_A988);
    send_req(rsst_pkg::CMD_QUERY,  10'd341,  10'd682,  32'h0);
    send_req(rsst_pkg::CMD_QUERY,  10'd0,    10'd1023, 32'h0);
    drain_results();

    // load-heavy first so later queries see populated ranges
    gen_traffic(150, 70);
    drain_results();

    // output held off while requests keep coming: block must back up
    long_hold_go = 1'b1;
    gen_traffic(250, 50);
    drain_results();

    gen_traffic(300, 40);
    drain_results();
    repeat (40) @(posedge clk);

    $display("run: %0d requests, %0d sums checked, %0d of them range queries",
             reqs_sent, sums_checked, queries_seen);
    $display("run: extreme values, empty and whole-array ranges, %0d-cycle output hold",
             LONG_HOLD);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
